@@ rtl/core/load_cell_adc_reader_assert.svh @@
// ----------------------------------------------------------------------------
// load_cell_adc_reader_assert
// Assertion macros for the load cell reader.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_ADC_READER_ASSERT_SVH
`define LOAD_CELL_ADC_READER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LCR_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define LCR_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/core/lcr_pkg.sv @@
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and codes of the load cell converter reader.
// ----------------------------------------------------------------------------
`default_nettype none
package lcr_pkg;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_MEASURE = 3'd1;
    localparam logic [2:0] FUNC_TARE    = 3'd2;
    localparam logic [2:0] FUNC_PDOWN   = 3'd3;
    localparam logic [2:0] FUNC_PUP     = 3'd4;
    localparam logic [2:0] FUNC_LOADOFS = 3'd5;
    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic clear_sum;   // start of run
        logic clear_word;  // start of reading
        logic shift_bit;   // sample data bit
        logic add_word;    // add shifted word to sum
        logic add_zero;    // count a not-ready reading
        logic start_div;   // begin averaging
        logic load_ofs;    // take offset from input
    } lcr_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic div_done;    // final result ready (one cycle)
    } lcr_sts_t;
endpackage
`default_nettype wire

@@ rtl/core/lcr_datapath.sv @@
// ----------------------------------------------------------------------------
// lcr_datapath
// Shift register, running sum, serial divider, offset and scaling.
// ----------------------------------------------------------------------------
`default_nettype none
module lcr_datapath #(
    parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  lcr_pkg::lcr_cmd_t cmd,
    output lcr_pkg::lcr_sts_t sts,
    input  wire               dout_level,
    input  wire signed [23:0] offset_value,
    input  wire         [7:0] count,
    input  wire signed [31:0] scale,
    input  wire               tare,
    output logic signed [23:0] avg_out,
    output logic signed [24:0] net_out,
    output logic signed [31:0] units_out
);
    localparam logic [1:0] DS_IDLE = 2'd0;
    localparam logic [1:0] DS_DIV  = 2'd1;
    localparam logic [1:0] DS_NET  = 2'd2;
    localparam logic [1:0] DS_MUL  = 2'd3;

    logic [SAMPLE_BITS-1:0] word_reg;
    logic signed [40:0]     sum_reg;     // 255 * 2^31 fits
    logic signed [40:0]     sum_next;
    logic signed [23:0]     offset_reg;
    logic [1:0]             ds_reg;
    logic [5:0]             cnt_reg;
    logic [40:0]            quo_reg;
    logic [8:0]             rem_reg;
    logic                   neg_reg;
    logic signed [40:0]     avg_reg;
    logic signed [24:0]     net_reg;
    logic signed [56:0]     prod_reg;
    logic                   done_reg;

    logic [40:0] abs_sum;
    logic [9:0]  rem_try;
    logic signed [41:0] net_full;
    logic signed [56:0] q;

    // sum including the word that ends this reading, so the divider
    // starts on the complete run
    always_comb begin
        sum_next = sum_reg;
        if (cmd.clear_sum) sum_next = '0;
        if (cmd.add_word) sum_next = sum_reg + 41'(signed'(word_reg));
    end

    assign abs_sum = sum_next[40] ? 41'(-sum_next) : 41'(sum_next);
    assign rem_try = {rem_reg, quo_reg[40]};
    assign net_full = 42'(avg_reg) - 42'(offset_reg);
    // floor of product / 2^16 is an arithmetic shift
    assign q = prod_reg >>> 16;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg   <= '0;
            sum_reg    <= '0;
            offset_reg <= '0;
            ds_reg     <= DS_IDLE;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.load_ofs) offset_reg <= offset_value;
            if (cmd.clear_word) word_reg <= '0;
            if (cmd.shift_bit) word_reg <= {word_reg[SAMPLE_BITS-2:0], dout_level};
            sum_reg <= sum_next;
            case (ds_reg)
                DS_IDLE: begin
                    if (cmd.start_div) begin
                        ds_reg  <= DS_DIV;
                        quo_reg <= abs_sum;
                        rem_reg <= '0;
                        neg_reg <= sum_next[40];
                        cnt_reg <= 6'd41;
                    end
                end
                DS_DIV: begin
                    if (rem_try >= {2'b0, count}) begin
                        rem_reg <= 9'(rem_try - {2'b0, count});
                        quo_reg <= {quo_reg[39:0], 1'b1};
                    end else begin
                        rem_reg <= rem_try[8:0];
                        quo_reg <= {quo_reg[39:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) ds_reg <= DS_NET;
                end
                DS_NET: begin
                    avg_reg <= neg_reg ? 41'(-quo_reg) : 41'(quo_reg);
                    ds_reg  <= DS_MUL;
                end
                DS_MUL: begin
                    if (net_full > 42'sd16777215) net_reg <= 25'sd16777215;
                    else if (net_full < -42'sd16777216) net_reg <= -25'sd16777216;
                    else net_reg <= 25'(net_full);
                    ds_reg <= DS_IDLE;
                    done_reg <= 1'b1;
                    if (tare) offset_reg <= avg_reg[23:0];
                end
                default: ds_reg <= DS_IDLE;
            endcase
            if (done_reg) prod_reg <= 57'(net_reg) * 57'(scale);
        end
    end

    // product is registered in the cycle after done; div_done is delayed to match
    logic done_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) done_d_reg <= 1'b0;
        else done_d_reg <= done_reg;
    end

    assign sts.div_done = done_d_reg;
    assign avg_out = avg_reg[23:0];
    assign net_out = net_reg;
    always_comb begin
        if (q > 57'sd2147483647) units_out = 32'sh7fffffff;
        else if (q < -57'sd2147483648) units_out = 32'sh80000000;
        else units_out = q[31:0];
    end
endmodule
`default_nettype wire

@@ rtl/core/lcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcr_ctrl
// Tick sequencer: handshakes, phase counter, converter clock, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "load_cell_adc_reader_assert.svh"
module lcr_ctrl #(
    parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire         [2:0] s_func,
    input  wire               s_dout_level,
    input  wire               m_ready,
    output logic              m_valid,
    output logic              m_sck_level,
    output logic              m_busy_res,
    output logic              m_result_valid,
    output logic              m_was_tare,
    input  wire         [1:0] gain,
    input  wire         [7:0] count_cfg,
    output logic        [7:0] count,
    output logic              tare,
    output lcr_pkg::lcr_cmd_t cmd,
    input  lcr_pkg::lcr_sts_t sts
);
    localparam int PW = $clog2(2*SAMPLE_BITS + 8);
    localparam logic [1:0] ST_TICK = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;   // averaging
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]    st_reg;
    logic [PW-1:0] phase_reg;   // 0 idle, 1 ready check, 2+k half tick k
    logic [7:0]    done_cnt_reg;
    logic [7:0]    count_reg;
    logic [1:0]    pulses_reg;
    logic          tare_reg;
    logic          sck_reg;
    logic          rv_reg;

    logic acc;
    logic [PW-1:0] half;
    logic [PW-1:0] last_half;
    logic fin;       // a reading ends this tick
    logic run_end;

    assign acc = s_valid && s_ready;
    assign s_ready = (st_reg == ST_TICK);
    assign half = phase_reg - PW'(2);
    assign last_half = PW'(2*SAMPLE_BITS - 1) + PW'({pulses_reg, 1'b0});
    assign count = count_reg;
    assign tare = tare_reg;

    always_comb begin
        cmd = '0;
        fin = 1'b0;
        if (acc && s_func != lcr_pkg::FUNC_PDOWN && s_func != lcr_pkg::FUNC_PUP) begin
            cmd.load_ofs = (s_func == lcr_pkg::FUNC_LOADOFS);
            if (phase_reg == '0) begin
                cmd.clear_sum = (s_func == lcr_pkg::FUNC_MEASURE) ||
                                (s_func == lcr_pkg::FUNC_TARE);
            end else if (phase_reg == PW'(1)) begin
                fin = s_dout_level;
                cmd.clear_word = !s_dout_level;
            end else if (half[0]) begin
                cmd.shift_bit = (half < PW'(2*SAMPLE_BITS));
                fin = (half == last_half);
                cmd.add_word = fin;
            end
        end
        cmd.add_zero = fin && !cmd.add_word;
        run_end = fin && (done_cnt_reg + 8'd1 >= count_reg);
        cmd.start_div = run_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_TICK;
            phase_reg <= '0;
            done_cnt_reg <= '0;
            count_reg <= '0;
            pulses_reg <= '0;
            tare_reg <= 1'b0;
            sck_reg <= 1'b0;
            rv_reg <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            case (st_reg)
                ST_TICK: begin
                    if (acc) begin
                        rv_reg <= 1'b0;
                        if (s_func == lcr_pkg::FUNC_PDOWN) begin
                            phase_reg <= '0;
                            sck_reg <= 1'b1;
                        end else if (s_func == lcr_pkg::FUNC_PUP) begin
                            phase_reg <= '0;
                            sck_reg <= 1'b0;
                        end else if (phase_reg == '0) begin
                            if (cmd.clear_sum) begin
                                phase_reg <= PW'(1);
                                tare_reg <= (s_func == lcr_pkg::FUNC_TARE);
                                done_cnt_reg <= '0;
                                count_reg <= (count_cfg == '0) ? 8'd1 : count_cfg;
                            end
                        end else if (phase_reg == PW'(1)) begin
                            sck_reg <= 1'b0;
                            if (!s_dout_level) begin
                                pulses_reg <= (gain == '0) ? 2'd1 : gain;
                                phase_reg <= PW'(2);
                            end
                        end else if (!half[0]) begin
                            sck_reg <= 1'b1;
                            phase_reg <= phase_reg + PW'(1);
                        end else begin
                            sck_reg <= 1'b0;
                            if (!fin) phase_reg <= phase_reg + PW'(1);
                        end
                        if (fin) begin
                            done_cnt_reg <= done_cnt_reg + 8'd1;
                            phase_reg <= run_end ? '0 : PW'(1);
                        end
                        if (run_end) begin
                            st_reg <= ST_WAIT;
                        end else begin
                            st_reg <= ST_OUT;
                            m_valid <= 1'b1;
                        end
                    end
                end
                ST_WAIT: begin
                    if (sts.div_done) begin
                        rv_reg <= 1'b1;
                        st_reg <= ST_OUT;
                        m_valid <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        st_reg <= ST_TICK;
                    end
                end
                default: st_reg <= ST_TICK;
            endcase
        end
    end

    assign m_sck_level = sck_reg;
    assign m_busy_res = (phase_reg != '0);
    assign m_result_valid = rv_reg;
    assign m_was_tare = rv_reg && tare_reg;

    `LCR_ASSERT_IMP(a_no_take_while_out, aclk, aresetn, m_valid, !s_ready)
    `LCR_ASSERT_NXT(a_end_idle, aclk, aresetn, run_end, phase_reg == '0)
    `LCR_ASSERT_IMP(a_tare_has_valid, aclk, aresetn, m_was_tare, m_result_valid)
endmodule
`default_nettype wire

@@ rtl/core/load_cell_adc_reader.sv @@
// A plain tick presents its result in the cycle after acceptance; a tick
// that ends a run waits for the serial averaging divider and scaling.
// One request in flight: a new request waits until the last result is taken.
// A reading is 1 + 2*(SAMPLE_BITS+pulses) requests; a run end adds the divider.
// Reset: synchronous, active low; phase idle, clock low, offset 0, registers
// to gain 1, count 1, scale 1.0.
// ----------------------------------------------------------------------------
// load_cell_adc_reader
// Two-wire bridge converter reader with averaging, tare and scaling.
// ----------------------------------------------------------------------------
`default_nettype none
module load_cell_adc_reader #(
    parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    // configuration write requests
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire         [1:0] cfg_index,
    input  wire        [31:0] cfg_data,
    // item requests
    input  wire               s_valid,
    output logic              s_ready,
    input  wire         [2:0] s_func,
    input  wire               s_dout_level,
    input  wire signed [23:0] s_offset_value,
    // result requests
    output logic              m_valid,
    input  wire               m_ready,
    output logic              m_sck_level,
    output logic              m_busy_res,
    output logic              m_result_valid,
    output logic              m_was_tare,
    output logic signed [23:0] m_average,
    output logic signed [24:0] m_net_value,
    output logic signed [31:0] m_units
);
    logic [1:0]         gain_reg;
    logic [7:0]         count_cfg_reg;
    logic signed [31:0] scale_reg;
    lcr_pkg::lcr_cmd_t  cmd;
    lcr_pkg::lcr_sts_t  sts;
    logic [7:0]         count;
    logic               tare;
    logic signed [23:0] avg;
    logic signed [24:0] net;
    logic signed [31:0] units;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= 2'd1;
            count_cfg_reg <= 8'd1;
            scale_reg <= 32'sd65536;
        end else if (cfg_valid) begin
            case (cfg_index)
                lcr_pkg::REG_GAIN:  gain_reg <= cfg_data[1:0];
                lcr_pkg::REG_COUNT: count_cfg_reg <= cfg_data[7:0];
                lcr_pkg::REG_SCALE: scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    lcr_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_func, .s_dout_level,
        .m_ready, .m_valid, .m_sck_level, .m_busy_res, .m_result_valid,
        .m_was_tare, .gain(gain_reg), .count_cfg(count_cfg_reg), .count, .tare,
        .cmd, .sts
    );

    lcr_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .aclk, .aresetn, .cmd, .sts, .dout_level(s_dout_level),
        .offset_value(s_offset_value), .count, .scale(scale_reg), .tare,
        .avg_out(avg), .net_out(net), .units_out(units)
    );

    // fields are zero unless a measure or tare completed; net and units also after a tare
    assign m_average   = m_result_valid ? avg : '0;
    assign m_net_value = (m_result_valid && !tare) ? net : '0;
    assign m_units     = (m_result_valid && !tare) ? units : '0;
endmodule
`default_nettype wire

@@ tb/sv/load_cell_adc_reader_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_adc_reader_tb
// Checks the converter reader against a cycle-free model of its tick sequence:
// every accepted request is run through the model, and each result request is
// compared field by field in order. Runs of readings are driven bit by bit
// with random data, gaps and back-pressure under several register settings.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_tb;

    localparam int NBITS     = 24;
    localparam int CYC_LIMIT = 1_000_000;
    localparam int DRAIN_CYC = 60;      // margin for the run-end divider and scaling

    // unused func codes act as a plain tick
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    typedef struct packed {
        logic               sck;
        logic               busy;
        logic               done;
        logic               tare;
        logic signed [23:0] avg;
        logic signed [24:0] net;
        logic signed [31:0] units;
    } reading_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the reader state and keeps the expected results
    // ------------------------------------------------------------------------
    class reader_scoreboard;
        // register copies
        logic [1:0]         gain;
        logic [7:0]         avg_cnt;
        logic signed [31:0] scale;
        // reader state
        int                 phase;
        logic [23:0]        word;
        int                 n_done;
        longint             sum;
        logic signed [23:0] offset;
        logic               tare_run;
        logic               sck;
        int                 pulses;
        int                 n_target;
        reading_t           pending_readings[$];
        int                 errors;

        function new();
            gain = 2'd1; avg_cnt = 8'd1; scale = 32'sd65536;
            phase = 0; word = '0; n_done = 0; sum = 0; offset = '0;
            tare_run = 1'b0; sck = 1'b0; pulses = 0; n_target = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                lcr_pkg::REG_GAIN:  gain = data[1:0];
                lcr_pkg::REG_COUNT: avg_cnt = data[7:0];
                lcr_pkg::REG_SCALE: scale = data;
                default: ;
            endcase
        endfunction

        // one reading finished: accumulate, and average at the end of a run
        function void finish_reading(longint v, inout reading_t r);
            longint a, n, p, u;
            sum += v;
            n_done++;
            if (n_done < n_target) begin
                phase = 1;
                return;
            end
            phase = 0;
            a = sum / n_target;             // truncates toward zero
            r.done = 1'b1;
            r.tare = tare_run;
            r.avg  = a[23:0];
            if (tare_run) begin
                offset = a[23:0];
                return;
            end
            n = a - longint'(offset);
            if (n > 16777215)  n = 16777215;
            if (n < -16777216) n = -16777216;
            r.net = n[24:0];
            p = n * longint'(scale);
            u = p >>> 16;                   // floor
            if (u > 64'sd2147483647)  u = 64'sd2147483647;
            if (u < -64'sd2147483648) u = -64'sd2147483648;
            r.units = u[31:0];
        endfunction

        function void note_request(logic [2:0] f, logic d, logic signed [23:0] ofs);
            reading_t r;
            int half;
            r = '0;
            if (f == lcr_pkg::FUNC_PDOWN) begin
                phase = 0; sck = 1'b1;
            end else if (f == lcr_pkg::FUNC_PUP) begin
                phase = 0; sck = 1'b0;
            end else begin
                if (f == lcr_pkg::FUNC_LOADOFS) offset = ofs;
                if (phase == 0) begin
                    if (f == lcr_pkg::FUNC_MEASURE || f == lcr_pkg::FUNC_TARE) begin
                        phase    = 1;
                        tare_run = (f == lcr_pkg::FUNC_TARE);
                        n_done   = 0;
                        sum      = 0;
                        n_target = (avg_cnt == 0) ? 1 : avg_cnt;
                    end
                end else if (phase == 1) begin
                    sck = 1'b0;
                    if (d) begin
                        finish_reading(0, r);       // not ready counts as 0
                    end else begin
                        pulses = (gain == 0) ? 1 : gain;
                        word   = '0;
                        phase  = 2;
                    end
                end else begin
                    half = phase - 2;
                    if (half % 2 == 0) begin
                        sck = 1'b1;
                        phase++;
                    end else begin
                        sck = 1'b0;
                        if (half < 2 * NBITS) word = {word[22:0], d};
                        if (half + 1 >= 2 * NBITS + 2 * pulses)
                            finish_reading(longint'($signed(word)), r);
                        else
                            phase++;
                    end
                end
            end
            r.sck  = sck;
            r.busy = (phase != 0);
            pending_readings.push_back(r);
        endfunction

        function void check_reading(reading_t got);
            reading_t w;
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected result request %h", $time, got);
                errors++;
                return;
            end
            w = pending_readings.pop_front();
            if (got.sck !== w.sck) begin
                $display("%0t: sck_level exp %0d got %0d", $time, w.sck, got.sck);
                errors++;
            end
            if (got.busy !== w.busy) begin
                $display("%0t: busy_res exp %0d got %0d", $time, w.busy, got.busy);
                errors++;
            end
            if (got.done !== w.done) begin
                $display("%0t: result_valid exp %0d got %0d", $time, w.done, got.done);
                errors++;
            end
            if (got.tare !== w.tare) begin
                $display("%0t: was_tare exp %0d got %0d", $time, w.tare, got.tare);
                errors++;
            end
            if (got.avg !== w.avg) begin
                $display("%0t: average exp %0d got %0d", $time, w.avg, got.avg);
                errors++;
            end
            if (got.net !== w.net) begin
                $display("%0t: net_value exp %0d got %0d", $time, w.net, got.net);
                errors++;
            end
            if (got.units !== w.units) begin
                $display("%0t: units exp %0d got %0d", $time, w.units, got.units);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_func = lcr_pkg::FUNC_TICK;
    logic               s_dout_level = 1'b0;
    logic signed [23:0] s_offset_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_sck_level, m_busy_res, m_result_valid, m_was_tare;
    logic signed [23:0] m_average;
    logic signed [24:0] m_net_value;
    logic signed [31:0] m_units;

    reader_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_sink = 1'b0;      // request a long receiver hold-off
    bit  no_gaps = 1'b0;        // stretch without idling on either side

    initial begin
        forever #6 aclk = ~aclk;
    end

    load_cell_adc_reader i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_dout_level   (s_dout_level),
        .s_offset_value (s_offset_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sck_level    (m_sck_level),
        .m_busy_res     (m_busy_res),
        .m_result_valid (m_result_valid),
        .m_was_tare     (m_was_tare),
        .m_average      (m_average),
        .m_net_value    (m_net_value),
        .m_units        (m_units)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("** load_cell_adc_reader: FAILED **");
            $finish;
        end
    end

    // result monitor: values sampled before the edge updates them
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_reading({m_sck_level, m_busy_res, m_result_valid, m_was_tare,
                              m_average, m_net_value, m_units});
    end

    // receiver: random stalls, a few long, and one long hold-off on request
    initial begin
        int r;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_sink = 1'b0;
            end else if (no_gaps) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(15, 50)) @(posedge aclk);
                end else begin
                    m_ready <= (r >= 25);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks (entered and left just after a rising edge)
    // ------------------------------------------------------------------------
    task automatic sender_gap();
        int r, n;
        n = 0;
        if (!no_gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 60 && r < 95) n = $urandom_range(1, 3);
            else if (r >= 95)      n = $urandom_range(15, 40);
        end
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send(logic [2:0] f, logic d, logic signed [23:0] ofs);
        sender_gap();
        s_valid        <= 1'b1;
        s_func         <= f;
        s_dout_level   <= d;
        s_offset_value <= ofs;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(f, d, ofs);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Command then ticks until the run ends. Sample ticks carry the bits of
    // value (random when rnd is set); the ready check reports not-ready with
    // probability busy_pct. noise_pct injects stray commands mid-run.
    task automatic run_cmd(logic [2:0] cmd, logic [23:0] value, bit rnd,
                           int busy_pct, int noise_pct);
        logic [23:0] v;
        logic [2:0]  f;
        logic        d;
        int          half, r;
        v = rnd ? 24'($urandom) : value;
        send(cmd, 1'b0, 24'($urandom));
        while (sb.phase != 0) begin
            f = lcr_pkg::FUNC_TICK;
            if ($urandom_range(0, 99) < noise_pct) begin
                r = $urandom_range(0, 6);
                case (r)
                    0: f = lcr_pkg::FUNC_MEASURE;
                    1: f = lcr_pkg::FUNC_TARE;
                    2: f = lcr_pkg::FUNC_LOADOFS;
                    3: f = FUNC_SPARE6;
                    4: f = FUNC_SPARE7;
                    5: f = lcr_pkg::FUNC_PDOWN;
                    default: f = lcr_pkg::FUNC_PUP;
                endcase
            end
            if (sb.phase == 1) begin
                d = ($urandom_range(0, 99) < busy_pct);
                if (rnd) v = 24'($urandom);
            end else begin
                half = sb.phase - 2;
                if (half % 2 == 1 && half < 2 * NBITS) d = v[NBITS - 1 - half / 2];
                else d = $urandom_range(0, 1);
            end
            send(f, d, 24'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int k, r;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle codes, offset extremes, power control, full scale
        send(lcr_pkg::FUNC_TICK, 1'b1, '0);
        send(FUNC_SPARE6, 1'b0, '0);
        send(FUNC_SPARE7, 1'b1, '0);
        send(lcr_pkg::FUNC_PDOWN, 1'b0, '0);
        send(lcr_pkg::FUNC_TICK, 1'b0, '0);          // clock stays high while idle
        send(lcr_pkg::FUNC_PUP, 1'b1, '0);
        send(lcr_pkg::FUNC_LOADOFS, 1'b0, 24'sh800000);
        run_cmd(lcr_pkg::FUNC_MEASURE, 24'h7FFFFF, 1'b0, 0, 0);
        send(lcr_pkg::FUNC_LOADOFS, 1'b0, 24'sh7FFFFF);
        run_cmd(lcr_pkg::FUNC_MEASURE, 24'h800000, 1'b0, 0, 0);
        run_cmd(lcr_pkg::FUNC_TARE, 24'hFFFFFF, 1'b0, 0, 0);
        run_cmd(lcr_pkg::FUNC_MEASURE, 24'h000000, 1'b0, 100, 0);   // data line not ready
        // commands while busy, then abort mid-run both ways
        send(lcr_pkg::FUNC_MEASURE, 1'b0, '0);
        send(lcr_pkg::FUNC_TICK, 1'b0, '0);
        send(lcr_pkg::FUNC_MEASURE, 1'b0, '0);
        send(lcr_pkg::FUNC_TARE, 1'b0, '0);
        send(lcr_pkg::FUNC_LOADOFS, 1'b1, 24'sh123456);
        send(lcr_pkg::FUNC_TICK, 1'b1, '0);
        send(lcr_pkg::FUNC_PDOWN, 1'b0, '0);
        send(lcr_pkg::FUNC_TARE, 1'b0, '0);
        send(lcr_pkg::FUNC_TICK, 1'b0, '0);
        send(lcr_pkg::FUNC_PUP, 1'b0, '0);
        wait_drained();

        // settings swept: extremes of every register, zero codes included
        for (k = 0; k < 6; k++) begin
            case (k)
                0: begin
                    write_reg(lcr_pkg::REG_GAIN, 32'd3);
                    write_reg(lcr_pkg::REG_COUNT, 32'd2);
                    write_reg(lcr_pkg::REG_SCALE, 32'h7FFFFFFF);
                end
                1: begin
                    write_reg(lcr_pkg::REG_GAIN, 32'd0);
                    write_reg(lcr_pkg::REG_COUNT, 32'd0);
                    write_reg(lcr_pkg::REG_SCALE, 32'h80000000);
                end
                2: begin
                    // full count, every reading not ready: short but deep run
                    write_reg(lcr_pkg::REG_GAIN, 32'd2);
                    write_reg(lcr_pkg::REG_COUNT, 32'd255);
                    write_reg(lcr_pkg::REG_SCALE, 32'h00000000);
                end
                3: begin
                    write_reg(lcr_pkg::REG_GAIN, 32'd1);
                    write_reg(lcr_pkg::REG_COUNT, 32'd3);
                    write_reg(lcr_pkg::REG_SCALE, $urandom);
                end
                4: begin
                    write_reg(lcr_pkg::REG_GAIN, 32'($urandom_range(0, 3)));
                    write_reg(lcr_pkg::REG_COUNT, 32'd1);
                    write_reg(lcr_pkg::REG_SCALE, $urandom);
                end
                default: begin
                    write_reg(lcr_pkg::REG_GAIN, 32'd3);
                    write_reg(lcr_pkg::REG_COUNT, 32'($urandom_range(1, 2)));
                    write_reg(lcr_pkg::REG_SCALE, 32'hFFFF0000);
                end
            endcase
            no_gaps = (k == 4);
            if (k == 2) begin
                run_cmd(lcr_pkg::FUNC_MEASURE, '0, 1'b1, 100, 0);
            end else begin
                repeat (1) begin
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        send(lcr_pkg::FUNC_LOADOFS, 1'($urandom), 24'($urandom));
                    else if (r < 15)
                        send(3'($urandom), 1'($urandom), 24'($urandom));
                    if (k == 3 && !hold_sink) hold_sink = 1'b1;  // fill the block
                    run_cmd(($urandom_range(0, 3) == 0) ? lcr_pkg::FUNC_TARE
                                                        : lcr_pkg::FUNC_MEASURE,
                            '0, 1'b1, 8, (r < 85) ? 0 : 5);
                end
            end
            no_gaps = 1'b0;
            wait_drained();     // sender pauses until every result is back
        end

        if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
            $display("** load_cell_adc_reader: PASSED **");
        end else begin
            $display("** load_cell_adc_reader: FAILED **");
        end
        $finish;
    end
endmodule
